/* rtl/spim_pkg.sv */
// ---------------------------------------------------------------------------
// spim_pkg
// Shared types and codes for the spi master with status pins: operation and
// register codes, control word bit positions and the transfer payloads.
// ---------------------------------------------------------------------------
package spim_pkg;

    // operation codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // register indexes
    localparam logic [1:0] REG_TX     = 2'd0;
    localparam logic [1:0] REG_RX     = 2'd1;
    localparam logic [1:0] REG_CTRL   = 2'd2;
    localparam logic [1:0] REG_STATUS = 2'd3;

    // control word layout
    localparam int CTL_SEL_BIT  = 0;
    localparam int CTL_WIDE_BIT = 1;
    localparam int CTL_LOOP_BIT = 2;
    localparam int CTL_DIV_LSB  = 8;
    localparam int CTL_DIV_MSB  = 15;
    localparam int NARROW_BITS  = 8;

    localparam logic [15:0] CTRL_RESET = 16'h0001;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [1:0]  reg_index;
        logic [31:0] write_value;
        logic        miso_pin;
        logic        card_detect_pin;
        logic        write_protect_pin;
    } in_item_t;

    typedef struct packed {
        logic [31:0] read_value;
        logic        sclk_level;
        logic        mosi_level;
        logic        select_n;
        logic        done_flag;
    } out_item_t;

endpackage

/* rtl/spi_master_with_status_pins_core.sv */
// ---------------------------------------------------------------------------
// spi_master_with_status_pins_core
// SPI master with tx, rx, control and status registers and card-detect /
// write-protect pass-through.
// ---------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_item carries one operation per transfer: a clock tick,
//   a register write or a register read, together with the sampled miso,
//   card-detect and write-protect pins.
//   m_valid/m_ready/m_item returns one result per operation: read data (zero
//   for ticks and writes) and the sclk, mosi, select and done pin levels
//   after the operation.
//   An accepted operation passes through one input register and one result
//   register, with the register step between them; m_valid is driven by the
//   result register.
//   Throughput is one operation per cycle while m_ready stays high, set by the
//   register step; while a result waits, the input register takes one more.
//   When m_ready is low the result register holds, the input register fills,
//   and s_ready drops only once both are occupied.
//   Reset (aresetn low, synchronous) empties both registers, deselects the
//   device, sets done, and clears the shifter, rx data and prescaler.
// ---------------------------------------------------------------------------
module spi_master_with_status_pins_core
    import spim_pkg::*;
#(
    parameter int WORD_BITS    = 32,
    parameter int DIVIDER_BITS = 8
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic      in_valid_reg, in_valid_next;
    in_item_t  in_item_reg;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg;
    out_item_t step_result;
    logic      advance;
    logic      s_accept;

    // handshake between the two registers
    assign advance  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    assign in_valid_next  = s_accept || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_ready);

    // register step
    spim_engine #(
        .WORD_BITS    (WORD_BITS),
        .DIVIDER_BITS (DIVIDER_BITS)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_item_reg),
        .result  (step_result)
    );

    // input and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
        if (s_accept) begin
            in_item_reg <= s_item;
        end
        if (advance) begin
            out_item_reg <= step_result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

endmodule

/* rtl/spim_engine.sv */
// ---------------------------------------------------------------------------
// spim_engine
// Register file, prescaler and shift engine. One step per enabled cycle:
// the next state and the pin view after the step are worked out in one pass.
// ---------------------------------------------------------------------------
module spim_engine
    import spim_pkg::*;
#(
    parameter int WORD_BITS    = 32,
    parameter int DIVIDER_BITS = 8
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      step_en,
    input  in_item_t  item,
    output out_item_t result
);

    localparam int CNT_BITS = $clog2(WORD_BITS + 1);

    logic [15:0]             control_reg, control_next;
    logic [WORD_BITS-1:0]    shifter_reg, shifter_next;
    logic [WORD_BITS-1:0]    rx_reg, rx_next;
    logic [CNT_BITS-1:0]     bits_left_reg, bits_left_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [DIVIDER_BITS-1:0] prescale_reg, prescale_next;
    logic                    clock_reg, clock_next;
    logic                    sample_reg, sample_next;

    logic                    wide_now;
    logic [WORD_BITS-1:0]    mask_now;
    logic                    mosi_now;
    logic [DIVIDER_BITS-1:0] divider;
    logic [CNT_BITS-1:0]     width_now;
    logic [CNT_BITS-1:0]     bits_dec;
    logic [WORD_BITS-1:0]    shifted;
    logic                    wide_after;
    logic [31:0]             read_data;
    logic                    tx_write;

    // current width and the data line as seen before the step
    assign wide_now  = control_reg[CTL_WIDE_BIT];
    assign mask_now  = wide_now ? {WORD_BITS{1'b1}}
                                : WORD_BITS'({NARROW_BITS{1'b1}});
    assign mosi_now  = wide_now ? shifter_reg[WORD_BITS-1] : shifter_reg[NARROW_BITS-1];
    assign width_now = wide_now ? CNT_BITS'(WORD_BITS) : CNT_BITS'(NARROW_BITS);
    assign divider   = DIVIDER_BITS'(control_reg[CTL_DIV_MSB:CTL_DIV_LSB]);
    assign shifted   = {shifter_reg[WORD_BITS-2:0], sample_reg} & mask_now;
    assign bits_dec  = (bits_left_reg != '0) ? bits_left_reg - 1'b1 : bits_left_reg;
    assign tx_write  = item.opcode == OP_WRITE && item.reg_index == REG_TX;

    // next state for one tick, write or read
    always_comb begin
        control_next   = control_reg;
        shifter_next   = shifter_reg;
        rx_next        = rx_reg;
        bits_left_next = bits_left_reg;
        busy_next      = busy_reg;
        done_next      = done_reg;
        prescale_next  = prescale_reg;
        clock_next     = clock_reg;
        sample_next    = sample_reg;
        read_data      = '0;
        unique case (item.opcode)
            OP_TICK: begin
                if (busy_reg) begin
                    if (prescale_reg != divider) begin
                        prescale_next = prescale_reg + 1'b1;
                    end else begin
                        prescale_next = '0;
                        if (!clock_reg) begin
                            // rising edge: take the sample
                            clock_next  = 1'b1;
                            sample_next = control_reg[CTL_LOOP_BIT] ? mosi_now
                                                                    : item.miso_pin;
                        end else begin
                            // falling edge: shift, count, maybe finish
                            clock_next     = 1'b0;
                            shifter_next   = shifted;
                            bits_left_next = bits_dec;
                            if (bits_dec == '0) begin
                                busy_next = 1'b0;
                                done_next = 1'b1;
                                rx_next   = shifted;
                            end
                        end
                    end
                end
            end
            OP_WRITE: begin
                if (item.reg_index == REG_TX) begin
                    shifter_next   = WORD_BITS'(item.write_value) & mask_now;
                    bits_left_next = width_now;
                    busy_next      = 1'b1;
                    done_next      = 1'b0;
                    prescale_next  = '0;
                    clock_next     = 1'b0;
                    sample_next    = 1'b0;
                end else if (item.reg_index == REG_CTRL) begin
                    control_next = item.write_value[15:0];
                end
            end
            OP_READ: begin
                unique case (item.reg_index)
                    REG_RX:     read_data = 32'(rx_reg);
                    REG_CTRL:   read_data = 32'(control_reg);
                    REG_STATUS: read_data = {29'd0, item.write_protect_pin,
                                             item.card_detect_pin, done_reg & ~busy_reg};
                    default:    read_data = '0;
                endcase
            end
            default: begin
            end
        endcase
    end

    // pin view after the step
    assign wide_after = control_next[CTL_WIDE_BIT];
    always_comb begin
        result.read_value = read_data;
        result.sclk_level = clock_next;
        result.mosi_level = wide_after ? shifter_next[WORD_BITS-1]
                                       : shifter_next[NARROW_BITS-1];
        result.select_n   = control_next[CTL_SEL_BIT];
        result.done_flag  = done_next & ~busy_next;
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            control_reg   <= CTRL_RESET;
            shifter_reg   <= '0;
            rx_reg        <= '0;
            bits_left_reg <= '0;
            busy_reg      <= 1'b0;
            done_reg      <= 1'b1;
            prescale_reg  <= '0;
            clock_reg     <= 1'b0;
            sample_reg    <= 1'b0;
        end else if (step_en) begin
            control_reg   <= control_next;
            shifter_reg   <= shifter_next;
            rx_reg        <= rx_next;
            bits_left_reg <= bits_left_next;
            busy_reg      <= busy_next;
            done_reg      <= done_next;
            prescale_reg  <= prescale_next;
            clock_reg     <= clock_next;
            sample_reg    <= sample_next;
        end
    end

    // a running transfer always has bits to go
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> bits_left_reg != '0)
        else $error("busy with no bits left");

    // serial clock and prescaler rest while idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> (!clock_reg && prescale_reg == '0))
        else $error("clock or prescaler active while idle");

    // done and busy are never both set or both clear
    assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg != busy_reg)
        else $error("done and busy out of step");

    // a tx write always starts a transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && tx_write) |=> (busy_reg && !done_reg))
        else $error("tx write did not start a transfer");

endmodule

/* bench/spi_master_with_status_pins_core_checker.sv */
// ---------------------------------------------------------------------------
// spi_master_with_status_pins_core_checker
// Watches both channels of the spi master core. Every accepted operation runs
// through a cycle-level model of the register file, prescaler and shifter.
// The pin levels and read data it predicts are queued, and each returned
// result is compared field by field with the oldest queued prediction.
// ---------------------------------------------------------------------------
module spi_master_with_status_pins_core_checker
    import spim_pkg::*;
#(
    parameter int WORD_BITS    = 32,
    parameter int DIVIDER_BITS = 8
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_item_t  s_item,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_item_t m_item,
    output int        fail_count,
    output int        pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 40;

    // model of the peripheral state
    logic [15:0]             ctl_reg;
    logic [31:0]             shift_reg;
    logic [31:0]             rx_data;
    logic [5:0]              bits_remaining;
    logic                    xfer_busy;
    logic                    xfer_done;
    logic [DIVIDER_BITS-1:0] presc_cnt;
    logic                    sclk_q;
    logic                    sampled_bit;

    out_item_t spi_result_q[$];
    int        err_cnt;
    int        pend_cnt;

    assign fail_count    = err_cnt;
    assign pending_count = pend_cnt;

    function automatic int cur_width();
        return ctl_reg[CTL_WIDE_BIT] ? WORD_BITS : NARROW_BITS;
    endfunction

    function automatic logic [31:0] cur_mask();
        logic [63:0] m;
        m = (64'd1 << cur_width()) - 64'd1;
        return m[31:0];
    endfunction

    function automatic logic mosi_now();
        return shift_reg[cur_width() - 1];
    endfunction

    // one system clock of the serial clock generator
    task automatic advance_sclk(input logic miso);
        logic [15:0]             div_field;
        logic [DIVIDER_BITS-1:0] div;
        div_field = {8'd0, ctl_reg[CTL_DIV_MSB:CTL_DIV_LSB]};
        div = div_field[DIVIDER_BITS-1:0];
        if (xfer_busy) begin
            if (presc_cnt != div) begin
                // counter may sit above a freshly lowered divider and wraps
                presc_cnt = presc_cnt + 1'b1;
            end else begin
                presc_cnt = '0;
                if (!sclk_q) begin
                    // rising edge: sample
                    sclk_q = 1'b1;
                    sampled_bit = ctl_reg[CTL_LOOP_BIT] ? mosi_now() : miso;
                end else begin
                    // falling edge: shift
                    sclk_q = 1'b0;
                    shift_reg = ((shift_reg << 1) | {31'd0, sampled_bit}) & cur_mask();
                    if (bits_remaining != 6'd0)
                        bits_remaining = bits_remaining - 6'd1;
                    if (bits_remaining == 6'd0) begin
                        xfer_busy = 1'b0;
                        xfer_done = 1'b1;
                        rx_data   = shift_reg;
                    end
                end
            end
        end
    endtask

    // apply one bus operation and work out the pins and read data after it
    task automatic apply_bus_op(input in_item_t op, output out_item_t res);
        res = '0;
        case (op.opcode)
            OP_TICK: begin
                advance_sclk(op.miso_pin);
            end
            OP_WRITE: begin
                if (op.reg_index == REG_TX) begin
                    // start (or restart) a transfer
                    shift_reg      = op.write_value & cur_mask();
                    bits_remaining = 6'(cur_width());
                    xfer_busy      = 1'b1;
                    xfer_done      = 1'b0;
                    presc_cnt      = '0;
                    sclk_q         = 1'b0;
                    sampled_bit    = 1'b0;
                end else if (op.reg_index == REG_CTRL) begin
                    ctl_reg = op.write_value[15:0];
                end
            end
            OP_READ: begin
                case (op.reg_index)
                    REG_RX:     res.read_value = rx_data;
                    REG_CTRL:   res.read_value = {16'd0, ctl_reg};
                    REG_STATUS: res.read_value = {29'd0, op.write_protect_pin,
                                                  op.card_detect_pin,
                                                  xfer_done && !xfer_busy};
                    default:    res.read_value = '0;
                endcase
            end
            default: ;
        endcase
        res.sclk_level = sclk_q;
        res.mosi_level = mosi_now();
        res.select_n   = ctl_reg[CTL_SEL_BIT];
        res.done_flag  = xfer_done && !xfer_busy;
    endtask

    task automatic compare_field(input string fname, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected %h, actual %h",
                         $time, fname, exp_v, act_v);
        end
    endtask

    // track transfers on both channels
    always @(posedge aclk) begin
        out_item_t exp_res;
        out_item_t new_res;
        if (!aresetn) begin
            ctl_reg        = CTRL_RESET;
            shift_reg      = '0;
            rx_data        = '0;
            bits_remaining = '0;
            xfer_busy      = 1'b0;
            xfer_done      = 1'b1;
            presc_cnt      = '0;
            sclk_q         = 1'b0;
            sampled_bit    = 1'b0;
            spi_result_q.delete();
            pend_cnt       = 0;
            err_cnt        = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (spi_result_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("%0t ns: unexpected result, expected none, actual %h",
                                 $time, m_item);
                end else begin
                    exp_res = spi_result_q.pop_front();
                    pend_cnt--;
                    compare_field("read_value", exp_res.read_value, m_item.read_value);
                    compare_field("sclk_level", {31'd0, exp_res.sclk_level},
                                  {31'd0, m_item.sclk_level});
                    compare_field("mosi_level", {31'd0, exp_res.mosi_level},
                                  {31'd0, m_item.mosi_level});
                    compare_field("select_n", {31'd0, exp_res.select_n},
                                  {31'd0, m_item.select_n});
                    compare_field("done_flag", {31'd0, exp_res.done_flag},
                                  {31'd0, m_item.done_flag});
                end
            end
            if (s_valid && s_ready) begin
                apply_bus_op(s_item, new_res);
                spi_result_q.push_back(new_res);
                pend_cnt++;
            end
        end
    end

endmodule

/* bench/spi_master_with_status_pins_core_tb.sv */
// ---------------------------------------------------------------------------
// spi_master_with_status_pins_core_tb
// Drives register writes, reads and clock ticks into the spi master core:
// a directed opening, then random transfers of random width, divider and
// loopback, with disturbances mid-transfer and bus noise, under several
// sender and receiver idling patterns. The checker does the comparing.
// ---------------------------------------------------------------------------
module spi_master_with_status_pins_core_tb;
    import spim_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_OPS   = 440;
    localparam int PHASE_COUNT  = 4;
    localparam int DRAIN_CYCLES = 8;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;
    int        fail_count;
    int        pending_count;

    int send_idle_pct;
    int rdy_stall_pct;
    int sent_count;
    int phase_limit;

    spi_master_with_status_pins_core DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    spi_master_with_status_pins_core_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_item        (s_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_item        (m_item),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // result side backpressure
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= (rdy_stall_pct == 0) || ($urandom_range(0, 99) >= rdy_stall_pct);
        end
    end

    // one transfer on the input channel, with random idle cycles ahead of it
    task automatic send_item(input in_item_t op);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= op;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_count++;
        @(negedge aclk);
    endtask

    task automatic send_op(input logic [1:0] opc, input logic [1:0] rsel,
                           input logic [31:0] val);
        in_item_t op;
        op.opcode            = opc;
        op.reg_index         = rsel;
        op.write_value       = val;
        op.miso_pin          = 1'($urandom_range(0, 1));
        op.card_detect_pin   = 1'($urandom_range(0, 1));
        op.write_protect_pin = 1'($urandom_range(0, 1));
        send_item(op);
    endtask

    // clock ticks with an occasional register read in between, cut short
    // once the current phase has sent its share
    task automatic run_ticks(input int n);
        for (int i = 0; i < n && sent_count < phase_limit; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_op(OP_READ, 2'($urandom_range(0, 3)), $urandom());
            send_op(OP_TICK, 2'($urandom_range(0, 3)), $urandom());
        end
    endtask

    // pause the sender until every outstanding result is back
    task automatic drain_results();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending_count != 0) @(negedge aclk);
    endtask

    // random control word: divider mostly small, wide mode only for small dividers
    function automatic logic [31:0] random_ctrl();
        logic [31:0] ctl;
        int          r;
        int          dv;
        ctl = $urandom();
        r   = $urandom_range(0, 99);
        if (r < 60)
            dv = 0;
        else if (r < 88)
            dv = $urandom_range(1, 3);
        else
            dv = $urandom_range(4, 31);
        ctl[CTL_DIV_MSB:CTL_DIV_LSB] = 8'(dv);
        ctl[CTL_WIDE_BIT] = (dv <= 3) && ($urandom_range(0, 99) < 35);
        return ctl;
    endfunction

    function automatic int ticks_for(input logic [31:0] ctl);
        int w;
        w = ctl[CTL_WIDE_BIT] ? 32 : NARROW_BITS;
        return 2 * w * (int'(ctl[CTL_DIV_MSB:CTL_DIV_LSB]) + 1);
    endfunction

    // either bus noise or a whole transfer with random content
    task automatic run_random_sequence();
        logic [31:0] ctl;
        logic [31:0] ctl2;
        int          n;
        if ($urandom_range(0, 99) < 15) begin
            repeat ($urandom_range(1, 4))
                send_op(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), $urandom());
        end else begin
            ctl = random_ctrl();
            send_op(OP_WRITE, REG_CTRL, ctl);
            send_op(OP_WRITE, REG_TX, $urandom());
            n = ticks_for(ctl);
            if ($urandom_range(0, 7) == 0) begin
                run_ticks($urandom_range(0, n - 1));
                if ($urandom_range(0, 1) == 0) begin
                    // restart while busy
                    send_op(OP_WRITE, REG_TX, $urandom());
                end else begin
                    // retune while busy: bits left stay, counter may wrap
                    ctl2 = random_ctrl();
                    ctl2[CTL_DIV_MSB:CTL_DIV_LSB] = 8'($urandom_range(0, 3));
                    send_op(OP_WRITE, REG_CTRL, ctl2);
                    n = 256 + 64 * (int'(ctl2[CTL_DIV_MSB:CTL_DIV_LSB]) + 1);
                end
            end
            run_ticks(n + $urandom_range(0, 3));
            send_op(OP_READ, REG_RX, $urandom());
            send_op(OP_READ, REG_STATUS, $urandom());
            if ($urandom_range(0, 3) == 0)
                send_op(OP_READ, REG_CTRL, $urandom());
            if ($urandom_range(0, 7) == 0)
                send_op(OP_READ, REG_TX, $urandom());
        end
    endtask

    // stimulus and verdict
    initial begin
        int base;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_item        = '0;
        send_idle_pct = 0;
        rdy_stall_pct = 0;
        sent_count    = 0;
        phase_limit   = 1_000_000_000;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset values, write-only and read-only registers, unused opcode
        send_op(OP_READ, REG_STATUS, 32'h0);
        send_op(OP_READ, REG_CTRL, 32'h0);
        send_op(OP_READ, REG_RX, 32'hFFFF_FFFF);
        send_op(OP_READ, REG_TX, 32'h0);
        send_op(OP_NONE, REG_CTRL, 32'hFFFF_FFFF);
        send_op(OP_TICK, REG_TX, 32'h0);
        send_op(OP_WRITE, REG_RX, 32'hFFFF_FFFF);
        send_op(OP_WRITE, REG_STATUS, 32'hFFFF_FFFF);

        // narrow transfer, fastest clock, device selected
        send_op(OP_WRITE, REG_CTRL, 32'h0000_0000);
        send_op(OP_WRITE, REG_TX, 32'hFFFF_FFA5);
        run_ticks(17);
        send_op(OP_READ, REG_RX, 32'h0);
        send_op(OP_READ, REG_STATUS, 32'h0);

        // wide loopback transfer
        send_op(OP_WRITE, REG_CTRL, 32'h0000_0006);
        send_op(OP_WRITE, REG_TX, 32'hFFFF_FFFF);
        run_ticks(65);
        send_op(OP_READ, REG_RX, 32'h0);

        // every control bit set, slowest divider; restart, then retune to
        // narrow mid-transfer with all 32 bits still to go
        send_op(OP_WRITE, REG_CTRL, 32'hFFFF_FFFF);
        send_op(OP_READ, REG_CTRL, 32'h0);
        send_op(OP_WRITE, REG_TX, 32'h8000_0001);
        run_ticks(24);
        send_op(OP_WRITE, REG_TX, 32'h1234_5678);
        send_op(OP_WRITE, REG_CTRL, 32'h0000_0000);
        run_ticks(2 * 32 + 2);
        send_op(OP_READ, REG_RX, 32'h0);
        send_op(OP_READ, REG_STATUS, 32'h0);
        drain_results();

        // random part in idling phases, sender paused between phases
        base = sent_count;
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  rdy_stall_pct = 0;  end
                1: begin send_idle_pct = 56; rdy_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  rdy_stall_pct = 56; end
                default: begin send_idle_pct = 26; rdy_stall_pct = 26; end
            endcase
            phase_limit = base + (ph + 1) * RANDOM_OPS / PHASE_COUNT;
            while (sent_count < phase_limit)
                run_random_sequence();
            drain_results();
        end

        // let any stray result show up
        send_idle_pct = 0;
        rdy_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0 && pending_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/spim_pkg.sv
rtl/spim_engine.sv
rtl/spi_master_with_status_pins_core.sv
bench/spi_master_with_status_pins_core_checker.sv
bench/spi_master_with_status_pins_core_tb.sv
